[rtl/core/qla_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qla_pkg
// Types, constants and helper functions for the tabular Q-learning agent.
// ----------------------------------------------------------------------------
package qla_pkg;

	localparam int X_W       = 3;
	localparam int Y_W       = 4;
	localparam int CELL_W    = X_W + Y_W;
	localparam int NUM_CELLS = 1 << CELL_W;
	localparam int NUM_ACT   = 4;
	localparam int ACT_W     = 2;
	localparam int CNT_W     = 3;
	localparam int VAL_W     = 32;
	localparam int ROW_W     = VAL_W * NUM_ACT;
	localparam int FRAC_W    = 16;
	localparam int COEF_W    = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [COEF_W-1:0] ONE_Q16       = COEF_W'(65536);
	localparam logic [COEF_W-1:0] ALPHA_RESET   = COEF_W'(32768);
	localparam logic [COEF_W-1:0] DISCNT_RESET  = COEF_W'(62259);
	localparam logic [COEF_W-1:0] EPSILON_RESET = COEF_W'(6554);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STEP  = 2'd1,
		OP_END   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA   = 2'd0,
		REG_DISCNT  = 2'd1,
		REG_EPSILON = 2'd2,
		REG_UNUSED  = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_CUR,
		S_CHOOSE,
		S_MUL_D,
		S_RD_PREV,
		S_DIFF,
		S_MUL_A,
		S_WRITE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [X_W-1:0]   state_x;
		logic [Y_W-1:0]   state_y;
		logic signed [31:0] reward;
		logic [15:0]      explore_draw;
		logic [7:0]       best_pick;
		logic [7:0]       other_pick;
	} qla_in_t;

	typedef struct packed {
		logic in_load;
		logic rd_en;
		logic rd_prev;
		logic choose_en;
		logic mul_d_en;
		logic diff_en;
		logic mul_a_en;
		logic wr_en;
		logic emit;
	} cmd_t;

	typedef struct packed {
		op_t  in_op;
		op_t  op_q;
		logic out_busy;
	} status_t;

	// pick mod n for n in 1..4; mod 3 by folding base-4 digits
	function automatic logic [ACT_W-1:0] pick_mod(input logic [7:0] pick,
			input logic [CNT_W-1:0] n);
		logic [3:0] s;
		logic [2:0] t;
		logic [ACT_W-1:0] r;
		s = 4'(pick[1:0]) + 4'(pick[3:2]) + 4'(pick[5:4]) + 4'(pick[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd3) t = t - 3'd3;
		if (t >= 3'd3) t = t - 3'd3;
		case (n)
			3'd2:    r = ACT_W'(pick[0]);
			3'd3:    r = t[ACT_W-1:0];
			3'd4:    r = pick[ACT_W-1:0];
			default: r = '0;
		endcase
		return r;
	endfunction

	// index of the k-th set bit of mask, counting from bit 0
	function automatic logic [ACT_W-1:0] nth_set(input logic [NUM_ACT-1:0] mask,
			input logic [ACT_W-1:0] k);
		logic [CNT_W-1:0] cnt;
		logic [ACT_W-1:0] r;
		cnt = '0;
		r = '0;
		for (int a = 0; a < NUM_ACT; a++) begin
			if (mask[a]) begin
				if (cnt == CNT_W'(k)) r = ACT_W'(a);
				cnt = cnt + CNT_W'(1);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/qla_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qla_if
// Valid/ready channels of the Q-learning agent: request and action result.
// ----------------------------------------------------------------------------
interface qla_in_if;
	logic             valid;
	logic             ready;
	qla_pkg::qla_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface qla_out_if;
	logic                      valid;
	logic                      ready;
	logic [qla_pkg::ACT_W-1:0] chosen_action;
	modport source (output valid, output chosen_action, input ready);
	modport sink   (input valid, input chosen_action, output ready);
endinterface
`default_nettype wire

[rtl/core/tabular_q_learning_agent.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tabular_q_learning_agent
// Tabular Q-learning agent with epsilon-greedy action choice on an 8x16 grid.
// ----------------------------------------------------------------------------
// One item at a time, set by a sequencer around a single table port and two
// registered multiplies: a start item reads its row and emits the choice, a
// step item also updates the previous row; an end item gives no result and
// only updates the previous row. The Q table is 128 rows of four actions with
// a per-row valid bit cleared at reset, so no clearing pass is needed. The
// next item is accepted while a result still waits to be taken.
module tabular_q_learning_agent (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	qla_in_if.sink                             in_ch,
	qla_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [qla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [qla_pkg::COEF_W-1:0]    cfg_data
);

	qla_pkg::cmd_t    cmd;
	qla_pkg::status_t status;
	logic             ready;

	qla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	qla_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_data       (in_ch.data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.chosen_action (out_ch.chosen_action)
	);

	assign in_ch.ready = ready;

endmodule
`default_nettype wire

[rtl/core/qla_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qla_ctrl
// Sequencer: table reads, action choice, the two multiplies and write-back.
// ----------------------------------------------------------------------------
module qla_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire qla_pkg::status_t  status,
	output qla_pkg::cmd_t          cmd
);

	qla_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= qla_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			qla_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					unique case (status.in_op)
						qla_pkg::OP_START, qla_pkg::OP_STEP: state_d = qla_pkg::S_RD_CUR;
						qla_pkg::OP_END:                     state_d = qla_pkg::S_RD_PREV;
						default:                             state_d = qla_pkg::S_IDLE;
					endcase
				end
			end
			qla_pkg::S_RD_CUR: begin
				cmd.rd_en = 1'b1;
				state_d   = qla_pkg::S_CHOOSE;
			end
			qla_pkg::S_CHOOSE: begin
				cmd.choose_en = 1'b1;
				state_d = (status.op_q == qla_pkg::OP_STEP) ? qla_pkg::S_MUL_D
				                                             : qla_pkg::S_EMIT;
			end
			qla_pkg::S_MUL_D: begin
				cmd.mul_d_en = 1'b1;
				state_d      = qla_pkg::S_RD_PREV;
			end
			qla_pkg::S_RD_PREV: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_prev = 1'b1;
				state_d     = qla_pkg::S_DIFF;
			end
			qla_pkg::S_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = qla_pkg::S_MUL_A;
			end
			qla_pkg::S_MUL_A: begin
				cmd.mul_a_en = 1'b1;
				state_d      = qla_pkg::S_WRITE;
			end
			qla_pkg::S_WRITE: begin
				cmd.wr_en = 1'b1;
				cmd.rd_prev = 1'b1;
				state_d = (status.op_q == qla_pkg::OP_END) ? qla_pkg::S_IDLE
				                                            : qla_pkg::S_EMIT;
			end
			qla_pkg::S_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = qla_pkg::S_IDLE;
				end
			end
			default: state_d = qla_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/qla_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qla_dp
// Datapath: Q table rows, config registers, choice logic, update arithmetic.
// ----------------------------------------------------------------------------
module qla_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire qla_pkg::qla_in_t               in_data,
	input  wire logic                           cfg_we,
	input  wire logic [qla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [qla_pkg::COEF_W-1:0]     cfg_data,
	input  wire qla_pkg::cmd_t                  cmd,
	output qla_pkg::status_t                    status,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [qla_pkg::ACT_W-1:0]           chosen_action
);

	localparam int DPROD_W = qla_pkg::COEF_W + 1 + qla_pkg::VAL_W;
	localparam int TGT_W   = qla_pkg::VAL_W + 2;
	localparam int DIFF_W  = TGT_W + 1;
	localparam int APROD_W = qla_pkg::COEF_W + 1 + DIFF_W;
	localparam int SUM_W   = APROD_W - qla_pkg::FRAC_W + 1;

	// one row holds all actions of a cell; a row never written reads as zero
	logic [qla_pkg::ROW_W-1:0]     mem [qla_pkg::NUM_CELLS];
	logic [qla_pkg::NUM_CELLS-1:0] row_valid_q;

	qla_pkg::qla_in_t              in_q;
	logic [qla_pkg::COEF_W-1:0]    alpha_q, discnt_q, epsilon_q;
	logic [qla_pkg::X_W-1:0]       prev_x_q;
	logic [qla_pkg::Y_W-1:0]       prev_y_q;
	logic [qla_pkg::ACT_W-1:0]     prev_act_q;
	logic                          out_valid_q;
	logic [qla_pkg::ACT_W-1:0]     out_act_q;

	logic [qla_pkg::ROW_W-1:0]     rd_data_q;
	logic                          rd_valid_q;
	logic [qla_pkg::ACT_W-1:0]     act_q;
	logic signed [qla_pkg::VAL_W-1:0] maxq_q;
	logic signed [DPROD_W-1:0]     dprod_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic signed [qla_pkg::VAL_W-1:0] old_q;
	logic signed [APROD_W-1:0]     aprod_q;

	logic [qla_pkg::CELL_W-1:0]    cur_cell, prev_cell, addr;
	logic [qla_pkg::COEF_W-1:0]    cfg_sat;
	logic signed [qla_pkg::VAL_W-1:0] lane [qla_pkg::NUM_ACT];
	logic signed [qla_pkg::VAL_W-1:0] m01, m23, row_max;
	logic [qla_pkg::NUM_ACT-1:0]   best_mask;
	logic [qla_pkg::CNT_W-1:0]     nb, no;
	logic                          explore;
	logic [qla_pkg::ACT_W-1:0]     pick_act;
	logic signed [TGT_W-1:0]       target;
	logic signed [qla_pkg::VAL_W-1:0] old_val, new_val;
	logic signed [SUM_W-1:0]       sum;
	logic [qla_pkg::ROW_W-1:0]     wr_row;

	assign cur_cell  = {in_q.state_x, in_q.state_y};
	assign prev_cell = {prev_x_q, prev_y_q};
	assign addr      = cmd.rd_prev ? prev_cell : cur_cell;
	assign cfg_sat   = cfg_data[qla_pkg::COEF_W-1] ? qla_pkg::ONE_Q16 : cfg_data;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_data_q <= mem[addr];
		if (cmd.wr_en) mem[addr] <= wr_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
			alpha_q     <= qla_pkg::ALPHA_RESET;
			discnt_q    <= qla_pkg::DISCNT_RESET;
			epsilon_q   <= qla_pkg::EPSILON_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_act_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_en) rd_valid_q <= row_valid_q[addr];
			if (cmd.wr_en) row_valid_q[addr] <= 1'b1;
			if (cfg_we) begin
				unique case (qla_pkg::cfg_reg_t'(cfg_index))
					qla_pkg::REG_ALPHA:   alpha_q   <= cfg_sat;
					qla_pkg::REG_DISCNT:  discnt_q  <= cfg_sat;
					qla_pkg::REG_EPSILON: epsilon_q <= cfg_sat;
					default: ;
				endcase
			end
			if (cmd.emit) begin
				prev_x_q    <= in_q.state_x;
				prev_y_q    <= in_q.state_y;
				prev_act_q  <= act_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// choice from the current row
	always_comb begin
		for (int a = 0; a < qla_pkg::NUM_ACT; a++)
			lane[a] = rd_valid_q ? $signed(rd_data_q[a*qla_pkg::VAL_W +: qla_pkg::VAL_W])
			                     : '0;
		m01 = (lane[1] > lane[0]) ? lane[1] : lane[0];
		m23 = (lane[3] > lane[2]) ? lane[3] : lane[2];
		row_max = (m23 > m01) ? m23 : m01;
		nb = '0;
		for (int a = 0; a < qla_pkg::NUM_ACT; a++) begin
			best_mask[a] = (lane[a] >= row_max);
			nb = nb + qla_pkg::CNT_W'(best_mask[a]);
		end
		no = qla_pkg::CNT_W'(qla_pkg::NUM_ACT) - nb;
		explore = ({1'b0, in_q.explore_draw} < epsilon_q) && (no != '0);
		pick_act = explore
			? qla_pkg::nth_set(~best_mask, qla_pkg::pick_mod(in_q.other_pick, no))
			: qla_pkg::nth_set(best_mask, qla_pkg::pick_mod(in_q.best_pick, nb));
	end

	// update arithmetic; >>> on signed values rounds toward minus infinity
	always_comb begin
		old_val = $signed(rd_data_q[prev_act_q*qla_pkg::VAL_W +: qla_pkg::VAL_W]);
		if (!rd_valid_q) old_val = '0;
		if (in_q.operation == qla_pkg::OP_STEP)
			target = TGT_W'(in_q.reward) + TGT_W'(dprod_q >>> qla_pkg::FRAC_W);
		else
			target = TGT_W'(in_q.reward);
		sum = SUM_W'(aprod_q >>> qla_pkg::FRAC_W) + SUM_W'(old_q);
		if (sum > SUM_W'(32'sh7FFF_FFFF))       new_val = 32'sh7FFF_FFFF;
		else if (sum < -SUM_W'(33'sh0_8000_0000)) new_val = 32'sh8000_0000;
		else                                     new_val = sum[qla_pkg::VAL_W-1:0];
		wr_row = rd_valid_q ? rd_data_q : '0;
		wr_row[prev_act_q*qla_pkg::VAL_W +: qla_pkg::VAL_W] = new_val;
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) in_q <= in_data;
		if (cmd.choose_en) begin
			act_q  <= pick_act;
			maxq_q <= row_max;
		end
		if (cmd.mul_d_en)
			dprod_q <= $signed({1'b0, discnt_q}) * DPROD_W'(maxq_q);
		if (cmd.diff_en) begin
			diff_q <= DIFF_W'(target) - DIFF_W'(old_val);
			old_q  <= old_val;
		end
		if (cmd.mul_a_en)
			aprod_q <= $signed({1'b0, alpha_q}) * APROD_W'(diff_q);
		if (cmd.emit) out_act_q <= act_q;
	end

	assign status.in_op    = qla_pkg::op_t'(in_data.operation);
	assign status.op_q     = qla_pkg::op_t'(in_q.operation);
	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign chosen_action   = out_act_q;

endmodule
`default_nettype wire

[rtl/core/qla_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qla_chk
// Port-level checks of the agent's channels.
// ----------------------------------------------------------------------------
module qla_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic [1:0]                in_op,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [qla_pkg::ACT_W-1:0] out_act
);

	// a result beat is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_act))
		else $error("result beat dropped or changed while stalled");

	// a real operation keeps the block busy in the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op != qla_pkg::OP_NONE |=> !in_ready)
		else $error("request accepted back to back");

	// an end beat never produces a result on the very next cycle
	a_end_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == qla_pkg::OP_END && !out_valid |=> !out_valid)
		else $error("end beat produced a result");

endmodule

bind tabular_q_learning_agent qla_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.data.operation),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_act   (out_ch.chosen_action)
);
`default_nettype wire
